### rtl/ntt_pkg.sv
// Shared types, constants and modular helpers for the NTT core.
// Depends on nothing; used by every module of the block.
`default_nettype none
package ntt_pkg;

  localparam int unsigned CW = 30;
  localparam int unsigned MaxLen = 256;
  localparam int unsigned Rows = MaxLen / 4;
  localparam int unsigned RowW = $clog2(Rows);

  localparam logic [29:0] MODP = 30'd998244353;
  localparam logic [31:0] MODP2 = 32'd1996488706;
  localparam logic [30:0] MU = 31'd1154949187;
  localparam logic [29:0] ROOT_FWD = 30'd15311432;
  localparam logic [29:0] ROOT_INV = 30'd469870224;
  localparam logic [4:0] ROOT_LOG = 5'd23;

  typedef struct packed {
    logic [29:0] coef_a;
    logic [29:0] coef_b;
    logic [29:0] coef_c;
    logic [29:0] coef_d;
  } coef_t;

  typedef struct packed {
    logic [29:0] value_a;
    logic [29:0] value_b;
    logic [29:0] value_c;
    logic [29:0] value_d;
    logic        final_group;
  } result_t;

  typedef logic [3:0][29:0] row_t;

  typedef struct packed {
    logic [29:0] u;
    logic [29:0] v;
    logic [29:0] w;
  } lane_in_t;

  typedef struct packed {
    logic [29:0] prod;
    logic [29:0] sum;
    logic [29:0] diff;
  } lane_out_t;

  function automatic logic [29:0] mod_add(logic [29:0] a, logic [29:0] b);
    logic [30:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODP}) s = s - {1'b0, MODP};
    return s[29:0];
  endfunction

  function automatic logic [29:0] mod_sub(logic [29:0] a, logic [29:0] b);
    logic [30:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else s = {1'b0, a} + {1'b0, MODP} - {1'b0, b};
    return s[29:0];
  endfunction

  function automatic logic [29:0] inv_len(logic [3:0] lg);
    logic [29:0] r;
    case (lg)
      4'd2: r = 30'd748683265;
      4'd3: r = 30'd873463809;
      4'd4: r = 30'd935854081;
      4'd5: r = 30'd967049217;
      4'd6: r = 30'd982646785;
      4'd7: r = 30'd990445569;
      default: r = 30'd994344961;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] bitrev8(logic [7:0] x);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = x[7-k];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/ntt_modmul.sv
// Four-stage pipelined multiplier modulo the prime, Barrett reduction.
// Depends on ntt_pkg.
`default_nettype none
module ntt_modmul (
  input  logic        clk_i,
  input  logic [29:0] a_i,
  input  logic [29:0] b_i,
  output logic [29:0] p_o
);
  import ntt_pkg::*;

  logic [59:0] x1_q;
  logic [30:0] q2_q;
  logic [31:0] x2_q;
  logic [31:0] r3_q;
  logic [61:0] qm;
  logic [60:0] qp;
  logic [31:0] r3_d;

  assign qm = 62'(x1_q[59:29]) * 62'(MU);
  assign qp = 61'(q2_q) * 61'(MODP);
  assign r3_d = x2_q - qp[31:0];

  always_ff @(posedge clk_i) begin
    x1_q <= 60'(a_i) * 60'(b_i);
    q2_q <= qm[61:31];
    x2_q <= x1_q[31:0];
    r3_q <= r3_d;
    if (r3_q >= MODP2) p_o <= 30'(r3_q - MODP2);
    else if (r3_q >= {2'b0, MODP}) p_o <= 30'(r3_q - {2'b0, MODP});
    else p_o <= r3_q[29:0];
  end

endmodule
`default_nettype wire

### rtl/ntt_lane.sv
// One butterfly lane: modular product v*w, then u plus and minus the product.
// Depends on ntt_pkg and ntt_modmul.
`default_nettype none
module ntt_lane (
  input  logic                clk_i,
  input  ntt_pkg::lane_in_t   lane_i,
  output ntt_pkg::lane_out_t  lane_o
);
  import ntt_pkg::*;

  logic [3:0][29:0] u_q;
  logic [29:0]      prod;
  logic [29:0]      sum_q;
  logic [29:0]      diff_q;

  ntt_modmul u_mul (
    .clk_i(clk_i),
    .a_i  (lane_i.v),
    .b_i  (lane_i.w),
    .p_o  (prod)
  );

  always_ff @(posedge clk_i) begin
    u_q    <= {u_q[2:0], lane_i.u};
    sum_q  <= mod_add(u_q[3], prod);
    diff_q <= mod_sub(u_q[3], prod);
  end

  assign lane_o = '{prod: prod, sum: sum_q, diff: diff_q};

endmodule
`default_nettype wire

### rtl/number_theoretic_transform_core.sv
// Top level of the NTT core: APB registers, row store, sequencer, four lanes.
// Depends on ntt_pkg, ntt_lane.
//
// After reset the core derives its stage roots and holds busy meanwhile.
// Each accepted word of four coefficients is then registered and written,
// one coefficient at a time, into the bit-reversed row store. The word that
// completes a block of N = 2^log_length starts the transform: the first two
// stages run together row by row, then each later stage sets up its twiddles
// and the four lanes work on one pair of store rows at a time; then the
// result words leave, one per cycle, with final_group on the last. The
// receiver cannot stall: results appear on result_o for exactly one cycle,
// marked by result_valid_o.
`default_nettype none
module number_theoretic_transform_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  ntt_pkg::coef_t    coef_i,
  output ntt_pkg::result_t  result_o,
  output logic              result_valid_o
);
  import ntt_pkg::*;

  localparam logic [2:0] ST_SETUP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_SMALL = 3'd3;
  localparam logic [2:0] ST_TWSET = 3'd4;
  localparam logic [2:0] ST_BIG   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]  state_q;
  logic [3:0]  ph_q;
  logic [4:0]  c_q;
  logic        m_q;
  logic [29:0] x_q;
  logic        inv_q;
  logic [3:0]  llen_q;
  logic [6:0]  gl_q;
  logic [5:0]  gcur_q;
  row_t        cf_q;
  logic [1:0]  lk_q;
  logic [3:0]  s_q;
  logic [4:0]  t_q;
  logic [RowW-1:0] r_q;
  logic        oi_q;
  logic [4:0]  ov_q;
  logic [4:0]  ol_q;
  logic [29:0] steps_q [16];
  logic [29:0] p2_q;
  logic [29:0] inc_q;
  row_t        tw_q;
  row_t        base_q;
  row_t        rowb_q;
  row_t        mem_q [Rows];
  row_t        rd_a_q;
  row_t        rd_b_q;

  logic [3:0]  lg;
  logic [6:0]  groups;
  logic [RowW-1:0] rlast;
  logic [4:0]  tlast;
  logic [5:0]  m6;
  logic [4:0]  mask;
  logic [RowW-1:0] row_a;
  logic [RowW-1:0] row_b;
  logic [29:0] st;
  logic [29:0] w4;
  logic [29:0] scale;
  logic [7:0]  raddr;
  logic        cfg_we;
  logic        accept;
  logic        out_fire;
  logic [29:0] a0, a1, a2, a3;

  logic            we;
  logic [RowW-1:0] wa;
  logic [3:0]      wmask;
  row_t            wd;
  logic [RowW-1:0] ra_a;
  logic [RowW-1:0] ra_b;

  lane_in_t  lin  [4];
  lane_out_t lout [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    ntt_lane u_lane (
      .clk_i (clk_i),
      .lane_i(lin[l]),
      .lane_o(lout[l])
    );
  end

  assign lg     = (llen_q < 4'd2) ? 4'd2 : ((llen_q > 4'd8) ? 4'd8 : llen_q);
  assign groups = 7'd1 << (lg - 4'd2);
  assign rlast  = RowW'(groups - 7'd1);
  assign tlast  = 5'((groups >> 1) - 7'd1);
  assign m6     = (6'd1 << (s_q - 4'd3)) - 6'd1;
  assign mask   = m6[4:0];
  assign row_a  = ({1'b0, t_q & ~mask} << 1) | {1'b0, t_q & mask};
  assign row_b  = row_a + RowW'(m6 + 6'd1);
  assign st     = steps_q[{inv_q, 3'(s_q - 4'd1)}];
  assign w4     = steps_q[{inv_q, 3'd1}];
  assign scale  = inv_q ? inv_len(lg) : 30'd1;
  assign raddr  = bitrev8({gcur_q, lk_q}) >> (4'd8 - lg);

  assign cfg_we   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? {28'd0, llen_q} : {31'd0, inv_q};
  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign out_fire = (state_q == ST_OUT) && oi_q;

  assign a0 = mod_add(rd_a_q[0], rd_a_q[1]);
  assign a1 = mod_sub(rd_a_q[0], rd_a_q[1]);
  assign a2 = mod_add(rd_a_q[2], rd_a_q[3]);
  assign a3 = mod_sub(rd_a_q[2], rd_a_q[3]);

  // lane operand select
  always_comb begin
    for (int l = 0; l < 4; l++) lin[l] = '0;
    unique case (state_q)
      ST_SETUP: begin
        lin[0].v = x_q;
        lin[0].w = x_q;
      end
      ST_SMALL: begin
        lin[0] = '{u: a0, v: a2, w: 30'd1};
        lin[1] = '{u: a1, v: a3, w: w4};
      end
      ST_TWSET: begin
        if (ph_q == 4'd0) begin
          lin[0].v = st;
          lin[0].w = st;
        end else begin
          lin[0].v = p2_q;
          lin[0].w = st;
          lin[1].v = p2_q;
          lin[1].w = p2_q;
        end
      end
      ST_BIG: begin
        for (int l = 0; l < 4; l++) begin
          if (ph_q == 4'd2) lin[l] = '{u: 30'd0, v: tw_q[l], w: inc_q};
          else lin[l] = '{u: rd_a_q[l], v: rd_b_q[l], w: tw_q[l]};
        end
      end
      ST_OUT: begin
        for (int l = 0; l < 4; l++) lin[l] = '{u: 30'd0, v: rd_a_q[l], w: scale};
      end
      default: begin
      end
    endcase
  end

  // store port select and merge of lane results into rows
  always_comb begin
    we    = 1'b0;
    wa    = r_q;
    wmask = 4'b1111;
    wd    = '0;
    ra_a  = r_q;
    ra_b  = row_b;
    unique case (state_q)
      ST_LOAD: begin
        we           = 1'b1;
        wa           = raddr[RowW+1:2];
        wmask        = 4'b0001 << raddr[1:0];
        wd[raddr[1:0]] = cf_q[lk_q];
      end
      ST_SMALL: begin
        we = (ph_q == 4'd6);
        wd = {lout[1].diff, lout[0].diff, lout[1].sum, lout[0].sum};
      end
      ST_BIG: begin
        ra_a = row_a;
        if (ph_q == 4'd6) begin
          we = 1'b1;
          wa = row_a;
          for (int l = 0; l < 4; l++) wd[l] = lout[l].sum;
        end else if (ph_q == 4'd7) begin
          we = 1'b1;
          wa = row_b;
          wd = rowb_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      for (int k = 0; k < 4; k++) begin
        if (wmask[k]) mem_q[wa][k] <= wd[k];
      end
    end
    rd_a_q <= mem_q[ra_a];
    rd_b_q <= mem_q[ra_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gl_q <= 7'd0;
    end else if (cfg_we) begin
      gl_q <= 7'd0;
    end else if (state_q == ST_LOAD && lk_q == 2'd3) begin
      gl_q <= ({1'b0, gcur_q} + 7'd1 == groups) ? 7'd0 : {1'b0, gcur_q} + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SETUP;
      ph_q    <= 4'd0;
      c_q     <= 5'd0;
      m_q     <= 1'b0;
      x_q     <= ROOT_FWD;
      inv_q   <= 1'b0;
      llen_q  <= 4'd8;
      gcur_q  <= 6'd0;
      lk_q    <= 2'd0;
      s_q     <= 4'd3;
      t_q     <= 5'd0;
      r_q     <= '0;
      oi_q    <= 1'b0;
      ov_q    <= 5'd0;
      ol_q    <= 5'd0;
    end else begin
      ov_q <= {ov_q[3:0], out_fire};
      ol_q <= {ol_q[3:0], out_fire && (r_q == rlast)};
      if (cfg_we) begin
        if (paddr[2]) llen_q <= pwdata[3:0];
        else inv_q <= pwdata[0];
      end
      unique case (state_q)
        ST_SETUP: begin
          if (ph_q == 4'd0) begin
            if (c_q >= 5'd15) steps_q[{m_q, 3'(5'd22 - c_q)}] <= x_q;
            if (c_q == ROOT_LOG - 5'd1) begin
              if (m_q) state_q <= ST_IDLE;
              m_q <= 1'b1;
              c_q <= 5'd0;
              x_q <= ROOT_INV;
            end else begin
              ph_q <= 4'd1;
            end
          end else if (ph_q == 4'd4) begin
            x_q  <= lout[0].prod;
            c_q  <= c_q + 5'd1;
            ph_q <= 4'd0;
          end else begin
            ph_q <= ph_q + 4'd1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cf_q[0] <= (coef_i.coef_a >= MODP) ? coef_i.coef_a - MODP : coef_i.coef_a;
            cf_q[1] <= (coef_i.coef_b >= MODP) ? coef_i.coef_b - MODP : coef_i.coef_b;
            cf_q[2] <= (coef_i.coef_c >= MODP) ? coef_i.coef_c - MODP : coef_i.coef_c;
            cf_q[3] <= (coef_i.coef_d >= MODP) ? coef_i.coef_d - MODP : coef_i.coef_d;
            gcur_q  <= (gl_q >= groups) ? 6'd0 : gl_q[5:0];
            lk_q    <= 2'd0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          lk_q <= lk_q + 2'd1;
          if (lk_q == 2'd3) begin
            if ({1'b0, gcur_q} + 7'd1 == groups) begin
              r_q     <= '0;
              ph_q    <= 4'd0;
              state_q <= ST_SMALL;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_SMALL: begin
          if (ph_q == 4'd6) begin
            ph_q <= 4'd0;
            if (r_q == rlast) begin
              r_q <= '0;
              if (lg == 4'd2) begin
                oi_q    <= 1'b1;
                state_q <= ST_OUT;
              end else begin
                s_q     <= 4'd3;
                state_q <= ST_TWSET;
              end
            end else begin
              r_q <= r_q + RowW'(1);
            end
          end else begin
            ph_q <= ph_q + 4'd1;
          end
        end
        ST_TWSET: begin
          if (ph_q == 4'd4) p2_q <= lout[0].prod;
          if (ph_q == 4'd9) begin
            base_q  <= {lout[0].prod, p2_q, st, 30'd1};
            tw_q    <= {lout[0].prod, p2_q, st, 30'd1};
            inc_q   <= lout[1].prod;
            t_q     <= 5'd0;
            ph_q    <= 4'd0;
            state_q <= ST_BIG;
          end else begin
            ph_q <= ph_q + 4'd1;
          end
        end
        ST_BIG: begin
          if (ph_q == 4'd6) begin
            for (int l = 0; l < 4; l++) rowb_q[l] <= lout[l].diff;
            if ((t_q & mask) == mask) tw_q <= base_q;
            else for (int l = 0; l < 4; l++) tw_q[l] <= lout[l].prod;
          end
          if (ph_q == 4'd7) begin
            ph_q <= 4'd0;
            if (t_q == tlast) begin
              if (s_q == lg) begin
                r_q     <= '0;
                oi_q    <= 1'b1;
                state_q <= ST_OUT;
              end else begin
                s_q     <= s_q + 4'd1;
                state_q <= ST_TWSET;
              end
            end else begin
              t_q <= t_q + 5'd1;
            end
          end else begin
            ph_q <= ph_q + 4'd1;
          end
        end
        ST_OUT: begin
          if (oi_q) begin
            if (r_q == rlast) oi_q <= 1'b0;
            else r_q <= r_q + RowW'(1);
          end else if (ov_q == 5'd0) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o       = ov_q[4];
  assign result_o.value_a     = lout[0].prod;
  assign result_o.value_b     = lout[1].prod;
  assign result_o.value_c     = lout[2].prod;
  assign result_o.value_d     = lout[3].prod;
  assign result_o.final_group = ol_q[4];

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for number_theoretic_transform_core: radix-2 NTT mod 998244353.
// Drives coefficient words and APB register writes, predicts every result word in a
// scoreboard class; depends on ntt_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;
  import ntt_pkg::*;

  localparam int unsigned ADDR_INVERSE = 0;
  localparam int unsigned ADDR_LOG_LEN = 4;
  localparam logic [29:0] HALF_INV = 30'd499122177;
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned TARGET_WORDS = 430;

  class ntt_scoreboard;
    logic [29:0] coef_store[256];
    int unsigned words_loaded;
    bit inverse;
    logic [3:0] log_len;
    result_t expected_q[$];
    int unsigned errors;

    function new();
      words_loaded = 0;
      inverse = 0;
      log_len = 4'd8;
      errors = 0;
      foreach (coef_store[i]) coef_store[i] = '0;
    endfunction

    function void write_reg(int unsigned addr, logic [31:0] data);
      if (addr == ADDR_INVERSE) inverse = data[0];
      else if (addr == ADDR_LOG_LEN) log_len = data[3:0];
      words_loaded = 0;
    endfunction

    function logic [29:0] mulm(logic [29:0] a, logic [29:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return 30'(p % 64'(MODP));
    endfunction

    function logic [29:0] addm(logic [29:0] a, logic [29:0] b);
      logic [30:0] s;
      s = 31'(a) + 31'(b);
      if (s >= 31'(MODP)) s = s - 31'(MODP);
      return s[29:0];
    endfunction

    function logic [29:0] subm(logic [29:0] a, logic [29:0] b);
      return (a >= b) ? a - b : 30'(31'(a) + 31'(MODP) - 31'(b));
    endfunction

    function void run_transform(int unsigned lg);
      int unsigned n, r, half;
      logic [29:0] t, step, w, u, v, ninv;
      n = 1 << lg;
      for (int unsigned i = 0; i < n; i++) begin
        r = 0;
        for (int unsigned k = 0; k < lg; k++) r |= ((i >> k) & 1) << (lg - 1 - k);
        if (i < r) begin
          t = coef_store[i];
          coef_store[i] = coef_store[r];
          coef_store[r] = t;
        end
      end
      for (int unsigned s = 1; s <= lg; s++) begin
        half = 1 << (s - 1);
        step = inverse ? ROOT_INV : ROOT_FWD;
        for (int unsigned k = 0; k < 23 - s; k++) step = mulm(step, step);
        for (int unsigned i = 0; i < n; i += half * 2) begin
          w = 30'd1;
          for (int unsigned j = 0; j < half; j++) begin
            u = coef_store[i + j];
            v = mulm(w, coef_store[i + j + half]);
            coef_store[i + j] = addm(u, v);
            coef_store[i + j + half] = subm(u, v);
            w = mulm(w, step);
          end
        end
      end
      if (inverse) begin
        ninv = 30'd1;
        for (int unsigned k = 0; k < lg; k++) ninv = mulm(ninv, HALF_INV);
        for (int unsigned i = 0; i < n; i++) coef_store[i] = mulm(coef_store[i], ninv);
      end
    endfunction

    function void note_word(coef_t c);
      int unsigned lg, groups, base;
      logic [29:0] f[4];
      result_t res;
      lg = (log_len < 2) ? 2 : (log_len > 8) ? 8 : log_len;
      groups = (1 << lg) >> 2;
      if (words_loaded >= groups) words_loaded = 0;
      base = words_loaded * 4;
      f = '{c.coef_a, c.coef_b, c.coef_c, c.coef_d};
      for (int j = 0; j < 4; j++)
        coef_store[(base + j) % 256] = (f[j] >= MODP) ? f[j] - MODP : f[j];
      words_loaded++;
      if (words_loaded < groups) return;
      run_transform(lg);
      words_loaded = 0;
      for (int unsigned g = 0; g < groups; g++) begin
        res.value_a = coef_store[4 * g];
        res.value_b = coef_store[4 * g + 1];
        res.value_c = coef_store[4 * g + 2];
        res.value_d = coef_store[4 * g + 3];
        res.final_group = (g + 1 == groups);
        expected_q.insert(expected_q.size(), res);
      end
    endfunction

    function void check_word(result_t got);
      result_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.value_a !== exp_w.value_a) begin
        $display("%0t: value_a expected %0d actual %0d", $time, exp_w.value_a, got.value_a);
        errors++;
      end
      if (got.value_b !== exp_w.value_b) begin
        $display("%0t: value_b expected %0d actual %0d", $time, exp_w.value_b, got.value_b);
        errors++;
      end
      if (got.value_c !== exp_w.value_c) begin
        $display("%0t: value_c expected %0d actual %0d", $time, exp_w.value_c, got.value_c);
        errors++;
      end
      if (got.value_d !== exp_w.value_d) begin
        $display("%0t: value_d expected %0d actual %0d", $time, exp_w.value_d, got.value_d);
        errors++;
      end
      if (got.final_group !== exp_w.final_group) begin
        $display("%0t: final_group expected %0b actual %0b", $time, exp_w.final_group,
                 got.final_group);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  coef_t coef_i = '0;
  result_t result_o;
  logic result_valid_o;

  ntt_scoreboard sb = new();
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  number_theoretic_transform_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .coef_i(coef_i),
    .result_o(result_o),
    .result_valid_o(result_valid_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_word(result_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic reg_write(int unsigned addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(addr);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(addr, data);
  endtask

  function automatic logic [29:0] rand_coef();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return MODP - 1;
      2: return 30'($urandom);
      default: return 30'($urandom_range(0, MODP - 1));
    endcase
  endfunction

  task automatic send_word(coef_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    start <= 1'b1;
    coef_i <= c;
    do @(posedge clk_i); while (busy);
    sb.note_word(c);
    words_sent++;
    burst_left--;
  endtask

  task automatic send_random(int unsigned count);
    coef_t c;
    repeat (count) begin
      c = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      send_word(c);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    int unsigned lg, groups;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // short blocks: extremes, unreduced words, both directions
    reg_write(ADDR_LOG_LEN, 32'd2);
    reg_write(ADDR_INVERSE, 32'd0);
    send_word('0);
    send_word({MODP - 30'd1, MODP - 30'd1, MODP - 30'd1, MODP - 30'd1});
    send_word({30'h3FFFFFFF, 30'h3FFFFFFF, MODP, 30'd1});
    send_word({30'd1, 30'd0, 30'd0, 30'd0});
    wait_idle();
    reg_write(ADDR_INVERSE, 32'd1);
    send_word({30'd1, 30'd2, 30'd3, 30'd4});
    send_word({MODP - 30'd1, 30'd0, 30'h3FFFFFFF, 30'd5});
    wait_idle();
    reg_write(ADDR_LOG_LEN, 32'd0);
    send_random(2);
    wait_idle();
    reg_write(ADDR_LOG_LEN, 32'd3);
    send_random(1);
    wait_idle();
    // drop the partial block
    reg_write(ADDR_INVERSE, 32'd0);
    send_random(4);
    wait_idle();

    while (words_sent < TARGET_WORDS) begin
      if ($urandom_range(0, 19) == 0) lg = $urandom_range(8, 15);
      else lg = $urandom_range(0, 7);
      reg_write(ADDR_LOG_LEN, 32'(lg));
      reg_write(ADDR_INVERSE, 32'($urandom_range(0, 1)));
      lg = (lg < 2) ? 2 : (lg > 8) ? 8 : lg;
      groups = (1 << lg) / 4;
      send_random(groups * ((lg >= 7) ? 1 : $urandom_range(1, 3)));
      if (groups > 1 && $urandom_range(0, 3) == 0) send_random($urandom_range(1, groups - 1));
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
